// ===== design/unsorted_min_extract_queue_macros.svh =====
// Assertion macros shared by the queue RTL.
// No dependencies; included by modules that carry assertions.
`ifndef UNSORTED_MIN_EXTRACT_QUEUE_MACROS_SVH
`define UNSORTED_MIN_EXTRACT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define UMEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("umeq assertion failed");

// Next-cycle implication, disabled in reset.
`define UMEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("umeq assertion failed");

`endif

// ===== design/umeq_pkg.sv =====
// Shared types and codes for the unsorted min-extract queue.
// No dependencies; used by umeq_cell and unsorted_min_extract_queue.
package umeq_pkg;

	localparam int VAL_W = 32;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELMIN = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Per-cycle command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0, // keep value
		CELL_PUSH  = 2'd1, // take from front neighbor (insert)
		CELL_PULL  = 2'd2, // take from back neighbor (scan rotation)
		CELL_CLOSE = 2'd3  // pull only at or behind the removed slot
	} cell_op_t;

endpackage

// ===== design/umeq_cell.sv =====
// One storage cell of the queue chain: a value register and its neighbor mux.
// Depends on umeq_pkg.
module umeq_cell #(
	parameter int IDX_W = 4,
	parameter logic [IDX_W-1:0] IDX = '0
) (
	input  logic                              clk,
	input  umeq_pkg::cell_op_t                op,
	input  logic [IDX_W-1:0]                  pos,      // slot removed on close
	input  logic signed [umeq_pkg::VAL_W-1:0] prev_val, // front neighbor
	input  logic signed [umeq_pkg::VAL_W-1:0] next_val, // back neighbor
	output logic signed [umeq_pkg::VAL_W-1:0] val
);

	logic signed [umeq_pkg::VAL_W-1:0] val_q;
	logic signed [umeq_pkg::VAL_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		case (op)
			umeq_pkg::CELL_PUSH:  val_d = prev_val;
			umeq_pkg::CELL_PULL:  val_d = next_val;
			umeq_pkg::CELL_CLOSE: val_d = (IDX >= pos) ? next_val : val_q;
			default:              val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

// ===== design/unsorted_min_extract_queue.sv =====
// Unsorted min-extract queue: chain of MAX_ENTRIES value cells, front at cell 0.
// Insert: result registered at the accept edge. Delete-min: the cells rotate as a
// ring through the scan state to find the minimum, then the close state removes it
// once the output is free; full-insert and empty-delete answer at once.
// One item in work at a time; inserts every cycle while results are taken.
// arst_n clears count, state and output valid; cell contents need no reset.
module unsorted_min_extract_queue #(
	parameter int MAX_ENTRIES = 16,
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int OUT_W = ((umeq_pkg::VAL_W + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// input beat
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // [31:0] value
	input  logic [0:0]       s_tuser,  // [0] action
	// result beat
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // [31:0] min_value, then fill_count, zero pad
	output logic [1:0]       m_tuser   // [1:0] status
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

	// Sequencer: idle, rotate-and-scan, close the gap.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_CLOSE = 3'b100
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_idx_q;   // chain position of the entry now at the head
	logic [IDX_W-1:0] min_pos_q;
	logic signed [umeq_pkg::VAL_W-1:0] min_q;

	logic out_valid_q;
	logic [1:0] out_status_q;
	logic signed [umeq_pkg::VAL_W-1:0] out_min_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic in_fire, out_take, out_free, is_full, is_empty;
	logic ins_ok, ins_full, del_empty, del_start, close_fire, scan_take;
	umeq_pkg::cell_op_t cell_op;
	logic signed [umeq_pkg::VAL_W-1:0] cell_val [MAX_ENTRIES];
	logic signed [umeq_pkg::VAL_W-1:0] head;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = s_tvalid && s_tready;
	assign out_take  = out_valid_q && m_tready;
	assign is_full   = (count_q == CNT_MAX);
	assign is_empty  = (count_q == '0);
	assign ins_ok    = in_fire && (s_tuser[0] == umeq_pkg::ACT_INSERT) && !is_full;
	assign ins_full  = in_fire && (s_tuser[0] == umeq_pkg::ACT_INSERT) && is_full;
	assign del_empty = in_fire && (s_tuser[0] == umeq_pkg::ACT_DELMIN) && is_empty;
	assign del_start = in_fire && (s_tuser[0] == umeq_pkg::ACT_DELMIN) && !is_empty;
	assign close_fire = (state_q == ST_CLOSE) && out_free;
	assign head = cell_val[0];

	// Head is a live entry older than the running minimum only if strictly smaller.
	assign scan_take = (scan_idx_q == '0) ||
		((CNT_W'(scan_idx_q) < count_q) && (head < min_q));

	always_comb begin
		cell_op = umeq_pkg::CELL_HOLD;
		if (ins_ok) begin
			cell_op = umeq_pkg::CELL_PUSH;
		end else if (state_q == ST_SCAN) begin
			cell_op = umeq_pkg::CELL_PULL;
		end else if (close_fire) begin
			cell_op = umeq_pkg::CELL_CLOSE;
		end
	end

	// Cell chain. During scan it is a ring: the head wraps to the tail, so after
	// MAX_ENTRIES steps every entry is back in place.
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		umeq_cell #(
			.IDX_W (IDX_W),
			.IDX   (IDX_W'(g))
		) u_cell (
			.clk      (clk),
			.op       (cell_op),
			.pos      (min_pos_q),
			.prev_val ((g == 0) ? s_tdata : cell_val[(g == 0) ? 0 : g - 1]),
			.next_val (cell_val[(g + 1) % MAX_ENTRIES]),
			.val      (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ins_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (del_start) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_idx_q == IDX_LAST) begin
						state_q    <= ST_CLOSE;
						scan_idx_q <= '0;
					end
				end
				ST_CLOSE: begin
					if (close_fire) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Running minimum; ties keep the entry nearer the front.
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && scan_take) begin
			min_q     <= head;
			min_pos_q <= scan_idx_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ins_ok || ins_full || del_empty || close_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_ok) begin
			out_status_q <= umeq_pkg::STAT_DONE;
			out_min_q    <= '0;
			out_cnt_q    <= count_q + CNT_W'(1);
		end else if (ins_full) begin
			out_status_q <= umeq_pkg::STAT_FULL;
			out_min_q    <= '0;
			out_cnt_q    <= count_q;
		end else if (del_empty) begin
			out_status_q <= umeq_pkg::STAT_EMPTY;
			out_min_q    <= '0;
			out_cnt_q    <= '0;
		end else if (close_fire) begin
			out_status_q <= umeq_pkg::STAT_DONE;
			out_min_q    <= min_q;
			out_cnt_q    <= count_q - CNT_W'(1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_W'({out_cnt_q, out_min_q});

	`include "unsorted_min_extract_queue_macros.svh"

	`UMEQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_MAX)
	`UMEQ_ASSERT_IMP(a_full_cnt, clk, arst_n, out_valid_q && (out_status_q == umeq_pkg::STAT_FULL), (out_cnt_q == CNT_MAX) && (out_min_q == '0))
	`UMEQ_ASSERT_IMP(a_empty_res, clk, arst_n, out_valid_q && (out_status_q == umeq_pkg::STAT_EMPTY), (out_cnt_q == '0) && (out_min_q == '0))
	`UMEQ_ASSERT_NXT(a_scan_to_close, clk, arst_n, (state_q == ST_SCAN) && (scan_idx_q == IDX_LAST), state_q == ST_CLOSE)
	`UMEQ_ASSERT_NXT(a_close_result, clk, arst_n, close_fire, out_valid_q && (out_status_q == umeq_pkg::STAT_DONE) && (state_q == ST_IDLE))

endmodule
